// ===== hw/rtl/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types and constants of the piecewise colormap pixel pipeline.
// ----------------------------------------------------------------------------
package cpm_pkg;

    localparam int MAX_POINTS = 6;
    localparam int TABLE_SIZE = 256;
    localparam int NUM_POINTS = 6;
    localparam int GRAY_W     = 17;
    localparam int IDX_W      = 8;
    localparam int REM_W      = 17;
    localparam int QUO_W      = 8;
    localparam int NUM_CH     = 3;

    typedef enum logic [2:0] {
        REG_PALETTE_MODE = 3'd0,
        REG_POINT_COUNT  = 3'd1,
        REG_POINT_0      = 3'd2,
        REG_POINT_1      = 3'd3,
        REG_POINT_2      = 3'd4,
        REG_POINT_3      = 3'd5,
        REG_POINT_4      = 3'd6,
        REG_POINT_5      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } point_t;

    typedef struct packed {
        logic                        palette_mode;
        logic [2:0]                  point_count;
        point_t [NUM_POINTS-1:0]     points;
    } cfg_t;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][7:0] rgb_t;

    typedef struct packed {
        rgb_t       start_col;
        rgb_t       end_col;
        logic [7:0] offset;
        logic [7:0] span;
    } seg_t;

    typedef struct packed {
        rgb_t                         base;
        logic [NUM_CH-1:0]            down;
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        logic [NUM_CH-1:0][QUO_W-1:0] quo;
        logic [7:0]                   span;
    } div_t;

endpackage

// ===== hw/rtl/cpm_index.sv =====
// ----------------------------------------------------------------------------
// cpm_index
// Scales the Q1.16 gray value to a rounded, saturated table index.
// ----------------------------------------------------------------------------
module cpm_index
    import cpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [GRAY_W-1:0] gray_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  idx
);

    localparam int SUM_W = GRAY_W + 8;

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [SUM_W-1:0] scaled;
    logic [SUM_W-16-1:0] whole;

    always_comb
    begin
        // value * 255 plus one half, ties round up
        scaled = ({gray_value, 8'd0} - SUM_W'(gray_value)) + SUM_W'(32768);
        whole  = scaled[SUM_W-1:16];
        if (whole > (SUM_W-16)'(TABLE_SIZE - 1))
        begin
            idx_next = IDX_W'(TABLE_SIZE - 1);
        end
        else
        begin
            idx_next = whole[IDX_W-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign idx       = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/cpm_segment.sv =====
// ----------------------------------------------------------------------------
// cpm_segment
// Picks the segment of the index and sets up start colour, offset and span.
// ----------------------------------------------------------------------------
module cpm_segment
    import cpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] idx,
    output logic             out_valid,
    input  logic             out_ready,
    output seg_t             seg
);

    logic       valid_reg;
    seg_t       seg_reg;
    seg_t       seg_next;
    logic [2:0] n;
    logic [2:0] last;
    logic [2:0] prev;
    logic [2:0] sel;
    point_t     sp;
    point_t     ep;
    point_t     tail_pt;
    point_t     col_pt;
    logic       tail;
    logic       flat;

    function automatic rgb_t colour_of(point_t p);
        rgb_t c;
        c[0] = p.red;
        c[1] = p.green;
        c[2] = p.blue;
        return c;
    endfunction

    always_comb
    begin
        if (cfg.point_count < 3'd2)
        begin
            n = 3'd2;
        end
        else if (cfg.point_count > 3'(MAX_POINTS))
        begin
            n = 3'(MAX_POINTS);
        end
        else
        begin
            n = cfg.point_count;
        end
        last = n - 3'd1;
        prev = n - 3'd2;

        // first segment whose end lies above the index wins
        sel = prev;
        for (int j = NUM_POINTS - 2; j >= 0; j--)
        begin
            if ((3'(j + 1) < n) && (idx < cfg.points[j+1].pos))
            begin
                sel = 3'(j);
            end
        end
        sp = cfg.points[sel];
        ep = cfg.points[sel + 3'd1];

        tail    = idx >= cfg.points[last].pos;
        tail_pt = cfg.palette_mode ? cfg.points[last] : cfg.points[prev];
        flat    = (idx < sp.pos) || !cfg.palette_mode || (ep.pos <= sp.pos);
        col_pt  = tail ? tail_pt : sp;

        if (tail || flat)
        begin
            // constant colour: zero offset over a span of one
            seg_next.start_col = colour_of(col_pt);
            seg_next.end_col   = colour_of(col_pt);
            seg_next.offset    = 8'd0;
            seg_next.span      = 8'd1;
        end
        else
        begin
            seg_next.start_col = colour_of(sp);
            seg_next.end_col   = colour_of(ep);
            seg_next.offset    = idx - sp.pos;
            seg_next.span      = ep.pos - sp.pos;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign seg       = seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            seg_reg <= seg_next;
        end
    end

endmodule

// ===== hw/rtl/cpm_mul.sv =====
// ----------------------------------------------------------------------------
// cpm_mul
// Colour difference times offset per channel, forming the dividend.
// ----------------------------------------------------------------------------
module cpm_mul
    import cpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  seg_t seg,
    output logic out_valid,
    input  logic out_ready,
    output div_t div
);

    logic  valid_reg;
    div_t  div_reg;
    div_t  div_next;
    logic [NUM_CH-1:0][7:0]  diff;
    logic [NUM_CH-1:0][15:0] prod;

    always_comb
    begin
        div_next.base = seg.start_col;
        div_next.span = seg.span;
        div_next.quo  = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            div_next.down[ch] = seg.end_col[ch] < seg.start_col[ch];
            diff[ch] = div_next.down[ch] ? (seg.start_col[ch] - seg.end_col[ch])
                                         : (seg.end_col[ch] - seg.start_col[ch]);
            prod[ch] = 16'(diff[ch] * seg.offset);
            // falling channels round the step up, so the quotient is a ceiling
            div_next.rem[ch] = REM_W'(prod[ch])
                + (div_next.down[ch] ? (REM_W'(seg.span) - REM_W'(1)) : REM_W'(0));
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign div       = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            div_reg <= div_next;
        end
    end

endmodule

// ===== hw/rtl/cpm_div_stage.sv =====
// ----------------------------------------------------------------------------
// cpm_div_stage
// One restoring division step: settles quotient bit SHIFT on all channels.
// ----------------------------------------------------------------------------
module cpm_div_stage
    import cpm_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t din,
    output logic out_valid,
    input  logic out_ready,
    output div_t dout
);

    logic             valid_reg;
    div_t             div_reg;
    div_t             div_next;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        div_next = din;
        trial    = REM_W'(din.span) << SHIFT;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (din.rem[ch] >= trial)
            begin
                div_next.rem[ch]        = din.rem[ch] - trial;
                div_next.quo[ch][SHIFT] = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign dout      = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            div_reg <= div_next;
        end
    end

endmodule

// ===== hw/rtl/piecewise_colormap_pixel.sv =====
// ----------------------------------------------------------------------------
// piecewise_colormap_pixel
// False-colour map of a gray pixel stream through up to six control points.
// ----------------------------------------------------------------------------
// One pixel enters per clock unless the output stalls; its colour passes index
// scaling, segment select, difference multiply, eight restoring division
// steps (one quotient bit each, shared by the three channels) and the output
// register that adds or subtracts the step. Each stage holds its item while
// the one after it is full, so a stalled output keeps accepting pixels until
// the pipeline is full. Control points and mode are written through the APB
// port and must be stable while pixels are in flight.
// ----------------------------------------------------------------------------
module piecewise_colormap_pixel
    import cpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] gray_value, [23:17] zero
    // colour output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int DIV_STAGES = QUO_W;

    // configuration registers
    logic                    mode_reg;
    logic [2:0]              count_reg;
    point_t [NUM_POINTS-1:0] points_reg;
    cfg_t                    cfg;
    reg_idx_t                addr_idx;
    logic                    wr_en;

    assign pready   = 1'b1;
    assign addr_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en    = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            count_reg  <= 3'd2;
            // second point all ones, the rest zero
            points_reg <= {{(NUM_POINTS-2){32'd0}}, 32'hFFFF_FFFF, 32'd0};
        end
        else if (wr_en)
        begin
            unique case (addr_idx)
                REG_PALETTE_MODE: mode_reg      <= pwdata[0];
                REG_POINT_COUNT:  count_reg     <= pwdata[2:0];
                REG_POINT_0:      points_reg[0] <= pwdata;
                REG_POINT_1:      points_reg[1] <= pwdata;
                REG_POINT_2:      points_reg[2] <= pwdata;
                REG_POINT_3:      points_reg[3] <= pwdata;
                REG_POINT_4:      points_reg[4] <= pwdata;
                REG_POINT_5:      points_reg[5] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (addr_idx)
            REG_PALETTE_MODE: prdata = {31'd0, mode_reg};
            REG_POINT_COUNT:  prdata = {29'd0, count_reg};
            REG_POINT_0:      prdata = points_reg[0];
            REG_POINT_1:      prdata = points_reg[1];
            REG_POINT_2:      prdata = points_reg[2];
            REG_POINT_3:      prdata = points_reg[3];
            REG_POINT_4:      prdata = points_reg[4];
            REG_POINT_5:      prdata = points_reg[5];
        endcase
    end

    assign cfg.palette_mode = mode_reg;
    assign cfg.point_count  = count_reg;
    assign cfg.points       = points_reg;

    // pipeline
    logic             idx_valid;
    logic             idx_ready;
    logic [IDX_W-1:0] idx;
    logic             seg_valid;
    logic             seg_ready;
    seg_t             seg;
    logic             div_valid [DIV_STAGES+1];
    logic             div_ready [DIV_STAGES+1];
    div_t             div_data  [DIV_STAGES+1];

    cpm_index u_index (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .gray_value (s_tdata[GRAY_W-1:0]),
        .out_valid  (idx_valid),
        .out_ready  (idx_ready),
        .idx        (idx)
    );

    cpm_segment u_segment (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .idx       (idx),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .seg       (seg)
    );

    cpm_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .seg       (seg),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .div       (div_data[0])
    );

    // quotient bits from the top down
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        cpm_div_stage #(
            .SHIFT (DIV_STAGES - 1 - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .din       (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .dout      (div_data[g+1])
        );
    end

    // output register
    logic             out_valid_reg;
    rgb_t             out_col_reg;
    rgb_t             out_col_next;
    div_t             fin;
    logic [NUM_CH-1:0][8:0] wide;

    assign fin = div_data[DIV_STAGES];
    assign div_ready[DIV_STAGES] = !out_valid_reg || m_tready;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            wide[ch] = fin.down[ch] ? ({1'b0, fin.base[ch]} - {1'b0, fin.quo[ch]})
                                    : ({1'b0, fin.base[ch]} + {1'b0, fin.quo[ch]});
            out_col_next[ch] = wide[ch][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready[DIV_STAGES])
        begin
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready[DIV_STAGES] && div_valid[DIV_STAGES])
        begin
            out_col_reg <= out_col_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg[2], out_col_reg[1], out_col_reg[0]};

`ifndef ASSERT_OFF
    // an empty output register lets the whole chain take a pixel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // division must leave a remainder below the span
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[DIV_STAGES] |->
            (fin.rem[0] < REM_W'(fin.span)) && (fin.rem[1] < REM_W'(fin.span))
            && (fin.rem[2] < REM_W'(fin.span)))
        else $error("division remainder not below span");

    // the step never carries out of or borrows past a channel
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[DIV_STAGES] |->
            !wide[0][8] && !wide[1][8] && !wide[2][8])
        else $error("colour step wrapped");

    // a result taken by the output register shows up on the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[DIV_STAGES] && div_ready[DIV_STAGES]) |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

// ===== tb/colormap_checker.sv =====
// ----------------------------------------------------------------------------
// colormap_checker
// Watches the register port and both pixel streams of the colormap, keeps
// its own copy of the palette, predicts the colour of every accepted gray
// pixel and compares each colour transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module colormap_checker
    import cpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] gray_value, [23:17] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output int          errors,
    output int          pending
);

    cfg_t shadow_cfg;
    rgb_t expected_colours[$];

    function automatic rgb_t colour_of(input point_t p);
        rgb_t c;
        c[0] = p.red;
        c[1] = p.green;
        c[2] = p.blue;
        return c;
    endfunction

    function automatic rgb_t map_gray(input logic [16:0] v);
        logic [31:0] scaled;
        int idx, n, seg, ps, pe, off, span, s, e, ch;
        rgb_t c0, c1, res;
        // round half up to the table index
        scaled = ({15'd0, v} * 32'd255 + 32'd32768) >> 16;
        idx = (scaled > 32'd255) ? 255 : int'(scaled);
        n = int'(shadow_cfg.point_count);
        if (n < 2)
            n = 2;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        if (idx >= int'(shadow_cfg.points[n-1].pos))
            return colour_of(shadow_cfg.palette_mode ? shadow_cfg.points[n-1]
                                                     : shadow_cfg.points[n-2]);
        // first segment whose end lies above the index
        seg = 0;
        while (seg + 2 < n && idx >= int'(shadow_cfg.points[seg+1].pos))
            seg++;
        ps = int'(shadow_cfg.points[seg].pos);
        pe = int'(shadow_cfg.points[seg+1].pos);
        if (idx < ps || !shadow_cfg.palette_mode || pe <= ps)
            return colour_of(shadow_cfg.points[seg]);
        off  = idx - ps;
        span = pe - ps;
        c0 = colour_of(shadow_cfg.points[seg]);
        c1 = colour_of(shadow_cfg.points[seg+1]);
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            s = int'(c0[ch]);
            e = int'(c1[ch]);
            // falling channels round the step up so both directions floor the value
            if (e >= s)
                res[ch] = 8'(s + ((e - s) * off) / span);
            else
                res[ch] = 8'(s - ((s - e) * off + span - 1) / span);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t     got, want;
        reg_idx_t r;
        int       ch;
        if (!rst_n)
        begin
            shadow_cfg              = '0;
            shadow_cfg.palette_mode = 1'b1;
            shadow_cfg.point_count  = 3'd2;
            shadow_cfg.points[1]    = '1;
            expected_colours.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                r = reg_idx_t'(paddr[4:2]);
                case (r)
                    REG_PALETTE_MODE: shadow_cfg.palette_mode = pwdata[0];
                    REG_POINT_COUNT:  shadow_cfg.point_count  = pwdata[2:0];
                    default:          shadow_cfg.points[int'(r) - int'(REG_POINT_0)] = pwdata;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_colours.size() == 0)
                begin
                    $display("%0t: colour transfer with nothing expected, got %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_colours.pop_front();
                    for (ch = 0; ch < NUM_CH; ch++)
                    begin
                        if (got[ch] !== want[ch])
                        begin
                            $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                     (ch == 0) ? "red" : (ch == 1) ? "green" : "blue",
                                     want[ch], got[ch]);
                            errors++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_colours.push_back(map_gray(s_tdata[16:0]));
            pending = expected_colours.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the colormap with directed and random gray pixels under a series of
// palettes written over the register port, with random idling on both
// streams and one long output stall; the checker predicts every colour.
// ----------------------------------------------------------------------------
module testbench;
    import cpm_pkg::*;

    localparam int LATENCY    = 12;
    localparam int HOLD_OFF   = 400;
    localparam int CYCLE_CAP  = 300000;
    localparam int RAND_PHASE = 12;
    localparam int PHASE_LEN  = 170;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    int     errors;
    int     pending;
    int     cycle_count;
    bit     gaps_on;
    bit     hold_request;
    point_t palette[NUM_POINTS];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    piecewise_colormap_pixel uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    colormap_checker colour_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // gray value that lands on table index k
    function automatic logic [16:0] gray_at(input int k);
        return 17'((k * 65536) / 255);
    endfunction

    function automatic logic [16:0] draw_gray();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(0, 600));
            1, 2:    return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic apb_write(input reg_idx_t r, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // palette changes only with the pipeline empty
    task automatic write_palette(input logic mode, input logic [2:0] count);
        int k;
        while (pending != 0)
            @(negedge clk);
        apb_write(REG_PALETTE_MODE, {31'd0, mode});
        apb_write(REG_POINT_COUNT, {29'd0, count});
        for (k = 0; k < NUM_POINTS; k++)
            apb_write(reg_idx_t'(int'(REG_POINT_0) + k), palette[k]);
    endtask

    task automatic randomize_palette(input logic [2:0] count);
        int pos_q[$];
        int k, last;
        for (k = 0; k < NUM_POINTS; k++)
            pos_q.push_back($urandom_range(0, 255));
        last = (count < 2) ? 1 : (count > MAX_POINTS) ? MAX_POINTS - 1 : count - 1;
        if ($urandom_range(0, 3) != 0)
        begin
            pos_q.sort();
            if ($urandom_range(0, 1))
                pos_q[0] = 0;
            if ($urandom_range(0, 1))
                pos_q[last] = 255;
        end
        for (k = 0; k < NUM_POINTS; k++)
        begin
            palette[k]     = point_t'($urandom);
            palette[k].pos = 8'(pos_q[k]);
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_pixel(input logic [16:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // output side: random back-pressure plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_OFF;
            end
            else
                gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int       ph, j;
        logic     mode;
        logic [2:0] count;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset palette: black to white over the whole range, rounding tie
        send_pixel(17'd0);
        send_pixel(17'd1);
        send_pixel(17'd32767);
        send_pixel(17'd32768);
        send_pixel(17'd32769);
        send_pixel(17'd65535);
        send_pixel(17'd65536);
        send_pixel(17'd131071);
        end_burst();

        // flat sections, point count above the maximum
        palette[0] = {8'd20,  8'h11, 8'h22, 8'h33};
        palette[1] = {8'd60,  8'h44, 8'h55, 8'h66};
        palette[2] = {8'd100, 8'h77, 8'h88, 8'h99};
        palette[3] = {8'd140, 8'haa, 8'hbb, 8'hcc};
        palette[4] = {8'd180, 8'hdd, 8'hee, 8'hff};
        palette[5] = {8'd230, 8'h01, 8'h02, 8'h03};
        write_palette(1'b0, 3'd7);
        send_pixel(gray_at(0));
        send_pixel(gray_at(80));
        send_pixel(gray_at(230));
        send_pixel(gray_at(255));
        end_burst();

        // continuous, point count below two, falling, flat and rising channels
        palette[0] = {8'd10,  8'hff, 8'h80, 8'h00};
        palette[1] = {8'd200, 8'h00, 8'h80, 8'hff};
        write_palette(1'b1, 3'd0);
        send_pixel(gray_at(5));
        send_pixel(gray_at(10));
        send_pixel(gray_at(105));
        send_pixel(gray_at(199));
        send_pixel(gray_at(200));
        end_burst();

        // positions out of order with a zero-width segment
        palette[0] = {8'd50,  8'h10, 8'hf0, 8'h80};
        palette[1] = {8'd30,  8'h20, 8'he0, 8'h70};
        palette[2] = {8'd30,  8'h30, 8'hd0, 8'h60};
        palette[3] = {8'd240, 8'hc0, 8'h10, 8'h05};
        write_palette(1'b1, 3'd4);
        send_pixel(gray_at(20));
        send_pixel(gray_at(30));
        send_pixel(gray_at(40));
        send_pixel(gray_at(239));
        send_pixel(gray_at(240));
        end_burst();

        for (ph = 0; ph < RAND_PHASE; ph++)
        begin
            if (ph == 0)
            begin
                mode  = 1'b0;
                count = 3'd2;
            end
            else if (ph == 1)
            begin
                mode  = 1'b1;
                count = 3'd6;
            end
            else
            begin
                mode  = 1'($urandom_range(0, 1));
                count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(2, 6));
            end
            randomize_palette(count);
            write_palette(mode, count);
            gaps_on = (ph % 4 != 3);
            for (j = 0; j < PHASE_LEN; j++)
            begin
                if (ph == 5 && j == 20)
                    hold_request = 1'b1;
                send_pixel(draw_gray());
            end
            end_burst();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (4 * LATENCY) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
